FILE: rtl/core/binary_heap_priority_queue_core_macros.svh
// Assertion macros for the binary heap priority queue core.
// Included by the modules that check their own control and datapath.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define BHPQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `BHPQ_ASSERT(lbl, clk, rst_n, !(expr), msg)

`else

`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BHPQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/core/bhpq_pkg.sv
// Shared types, codes and the microprogram of the binary heap priority queue.
// No dependencies; used by the sequencer, the datapath and the top level.
package bhpq_pkg;

  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int UPC_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET       = 11'd1024;
  localparam logic             MIN_ORDER_RESET = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 1'b0,
    CFG_MIN_ORDER = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ZERO   = 3'd1,
    RD_LAST   = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4,
    RD_PARENT = 3'd5
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_VAL  = 2'd1,
    WR_PICK = 2'd2
  } wr_sel_e;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_ZERO   = 3'd1,
    POS_CNT    = 3'd2,
    POS_PICK   = 3'd3,
    POS_PARENT = 3'd4
  } pos_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [3:0] {
    COND_NEVER      = 4'd0,
    COND_ALWAYS     = 4'd1,
    COND_INSERT     = 4'd2,
    COND_EMPTY      = 4'd3,
    COND_NOT_REMOVE = 4'd4,
    COND_NO_LEFT    = 4'd5,
    COND_NO_RIGHT   = 4'd6,
    COND_DN_STOP    = 4'd7,
    COND_UP_STOP    = 4'd8,
    COND_AT_ROOT    = 4'd9,
    COND_FULL       = 4'd10
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  // Control word: one per microprogram step.
  typedef struct packed {
    logic     wait_in;
    logic     emit;
    status_e  emit_status;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    pos_sel_e pos_sel;
    cnt_op_e  cnt_op;
    logic     ld_res;
    logic     ld_val;
    logic     ld_left;
    logic     ld_right_if;
    logic     ld_upv;
    cond_e    cond;
    upc_t     target;
  } ctrl_t;

  // Datapath flags the sequencer branches on.
  typedef struct packed {
    logic insert;
    logic empty;
    logic not_remove;
    logic no_left;
    logic no_right;
    logic dn_stop;
    logic up_stop;
    logic at_root;
    logic full;
    logic out_busy;
  } flags_t;

  localparam upc_t STEP_IDLE      = 5'd0;
  localparam upc_t STEP_DISP      = 5'd1;
  localparam upc_t STEP_TOP       = 5'd2;
  localparam upc_t STEP_KIND      = 5'd3;
  localparam upc_t STEP_REM       = 5'd4;
  localparam upc_t STEP_DN_CHK    = 5'd5;
  localparam upc_t STEP_DN_L      = 5'd6;
  localparam upc_t STEP_DN_R      = 5'd7;
  localparam upc_t STEP_DN_CMP    = 5'd8;
  localparam upc_t STEP_DN_MOVE   = 5'd9;
  localparam upc_t STEP_PLACE     = 5'd10;
  localparam upc_t STEP_INS       = 5'd11;
  localparam upc_t STEP_INS_GO    = 5'd12;
  localparam upc_t STEP_UP_CHK    = 5'd13;
  localparam upc_t STEP_UP_WAIT   = 5'd14;
  localparam upc_t STEP_UP_MOVE   = 5'd15;
  localparam upc_t STEP_OUT_OK    = 5'd16;
  localparam upc_t STEP_OUT_FULL  = 5'd17;
  localparam upc_t STEP_OUT_EMPTY = 5'd18;
  localparam upc_t STEP_LAST      = STEP_OUT_EMPTY;

  // Microprogram ROM.
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '{wait_in: 1'b0, emit: 1'b0, emit_status: STATUS_OK, rd_sel: RD_NONE,
          wr_sel: WR_NONE, pos_sel: POS_HOLD, cnt_op: CNT_HOLD, ld_res: 1'b0,
          ld_val: 1'b0, ld_left: 1'b0, ld_right_if: 1'b0, ld_upv: 1'b0,
          cond: COND_NEVER, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_DISP;
      end
      STEP_DISP: begin
        w.rd_sel = RD_ZERO;
        w.cond   = COND_INSERT;
        w.target = STEP_INS;
      end
      STEP_TOP: begin
        w.ld_res = 1'b1;
        w.cond   = COND_EMPTY;
        w.target = STEP_OUT_EMPTY;
      end
      STEP_KIND: begin
        w.rd_sel = RD_LAST;
        w.cond   = COND_NOT_REMOVE;
        w.target = STEP_OUT_OK;
      end
      STEP_REM: begin
        w.ld_val  = 1'b1;
        w.cnt_op  = CNT_DEC;
        w.pos_sel = POS_ZERO;
      end
      STEP_DN_CHK: begin
        w.rd_sel = RD_LEFT;
        w.cond   = COND_NO_LEFT;
        w.target = STEP_PLACE;
      end
      STEP_DN_L: begin
        w.ld_left = 1'b1;
        w.rd_sel  = RD_RIGHT;
        w.cond    = COND_NO_RIGHT;
        w.target  = STEP_DN_CMP;
      end
      STEP_DN_R: begin
        w.ld_right_if = 1'b1;
      end
      STEP_DN_CMP: begin
        w.cond   = COND_DN_STOP;
        w.target = STEP_PLACE;
      end
      STEP_DN_MOVE: begin
        w.wr_sel  = WR_PICK;
        w.pos_sel = POS_PICK;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_DN_CHK;
      end
      STEP_PLACE: begin
        w.wr_sel = WR_VAL;
        w.cond   = COND_ALWAYS;
        w.target = STEP_OUT_OK;
      end
      STEP_INS: begin
        w.cond   = COND_FULL;
        w.target = STEP_OUT_FULL;
      end
      STEP_INS_GO: begin
        w.pos_sel = POS_CNT;
        w.cnt_op  = CNT_INC;
      end
      STEP_UP_CHK: begin
        w.rd_sel = RD_PARENT;
        w.cond   = COND_AT_ROOT;
        w.target = STEP_PLACE;
      end
      STEP_UP_WAIT: begin
        w.ld_upv = 1'b1;
        w.cond   = COND_UP_STOP;
        w.target = STEP_PLACE;
      end
      STEP_UP_MOVE: begin
        w.wr_sel  = WR_PICK;
        w.pos_sel = POS_PARENT;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_UP_CHK;
      end
      STEP_OUT_OK: begin
        w.emit        = 1'b1;
        w.emit_status = STATUS_OK;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_IDLE;
      end
      STEP_OUT_FULL: begin
        w.emit        = 1'b1;
        w.emit_status = STATUS_FULL;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_IDLE;
      end
      STEP_OUT_EMPTY: begin
        w.emit        = 1'b1;
        w.emit_status = STATUS_EMPTY;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/bhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bhpq_seq.sv
// Microprogram sequencer: step counter, control ROM lookup and branch logic.
// Depends on bhpq_pkg and the assertion macro header.
`include "binary_heap_priority_queue_core_macros.svh"

module bhpq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bhpq_pkg::flags_t flags_i,
  output bhpq_pkg::ctrl_t  ctrl_o
);
  import bhpq_pkg::*;

  upc_t  pc_q, pc_d;
  ctrl_t ctrl;
  logic  cond_true;
  logic  hold;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:      cond_true = 1'b0;
      COND_ALWAYS:     cond_true = 1'b1;
      COND_INSERT:     cond_true = flags_i.insert;
      COND_EMPTY:      cond_true = flags_i.empty;
      COND_NOT_REMOVE: cond_true = flags_i.not_remove;
      COND_NO_LEFT:    cond_true = flags_i.no_left;
      COND_NO_RIGHT:   cond_true = flags_i.no_right;
      COND_DN_STOP:    cond_true = flags_i.dn_stop;
      COND_UP_STOP:    cond_true = flags_i.up_stop;
      COND_AT_ROOT:    cond_true = flags_i.at_root;
      COND_FULL:       cond_true = flags_i.full;
      default:         cond_true = 1'b0;
    endcase
  end

  // Hold on an empty input channel or a full output register.
  assign hold = (ctrl.wait_in && !in_valid_i) || (ctrl.emit && flags_i.out_busy);

  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else if (cond_true) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  `BHPQ_ASSERT(a_emit_to_idle, clk_i, rst_ni, (ctrl.emit && !flags_i.out_busy) |=> (pc_q == STEP_IDLE), "sequencer did not return to idle after a result")
  `BHPQ_ASSERT(a_accept_to_disp, clk_i, rst_ni, (ctrl.wait_in && in_valid_i) |=> (pc_q == STEP_DISP), "accepted beat not dispatched")
  `BHPQ_ASSERT(a_pc_in_program, clk_i, rst_ni, pc_q <= STEP_LAST, "step counter left the program")

endmodule

FILE: rtl/core/bhpq_dp.sv
// Heap datapath: request, count and sift registers, RAM address and write
// selection, ordering compare, configuration and the result register.
// Depends on bhpq_pkg and the assertion macro header.
`include "binary_heap_priority_queue_core_macros.svh"

module bhpq_dp #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bhpq_pkg::ctrl_t                     ctrl_i,
  output bhpq_pkg::flags_t                    flags_o,
  input  logic                                cfg_we_i,
  input  logic [bhpq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bhpq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [bhpq_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [bhpq_pkg::VALUE_W-1:0] value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [bhpq_pkg::VALUE_W-1:0] result_value_o,
  output logic [bhpq_pkg::COUNT_W-1:0]        element_count_o,
  output logic [bhpq_pkg::STATUS_W-1:0]       status_o,
  output logic                                mem_we_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]       mem_waddr_o,
  output logic [bhpq_pkg::VALUE_W-1:0]        mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]       mem_raddr_o,
  input  logic [bhpq_pkg::VALUE_W-1:0]        mem_rdata_i
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int LW = AW + 2;
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic out_of_order(logic signed [VALUE_W-1:0] a,
                                        logic signed [VALUE_W-1:0] b,
                                        logic                      min_ord);
    return min_ord ? (a > b) : (a < b);
  endfunction

  logic [CAP_W-1:0]          cap_q;
  logic                      min_q;
  logic [MODE_W-1:0]         mode_q;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic signed [VALUE_W-1:0] res_q, res_d;
  logic signed [VALUE_W-1:0] pickv_q, pickv_d;
  logic [AW-1:0]             pick_q, pick_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [CW-1:0]             cnt_q, cnt_d;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_val_q;
  logic [COUNT_W-1:0]        out_cnt_q;
  logic [STATUS_W-1:0]       out_status_q;

  logic                      accept;
  logic                      emit_fire;
  logic                      full_w;
  logic signed [VALUE_W-1:0] rdata_s;
  logic [LW-1:0]             left_w, right_w;
  logic [AW-1:0]             parent_w;
  logic [AW-1:0]             last_w;

  assign accept    = ctrl_i.wait_in && in_valid_i;
  assign rdata_s   = $signed(mem_rdata_i);
  assign left_w    = LW'({pos_q, 1'b1});
  assign right_w   = left_w + LW'(1);
  assign parent_w  = (pos_q - AW'(1)) >> 1;
  assign last_w    = AW'(cnt_q - CW'(1));
  assign full_w    = (MW'(cnt_q) >= MW'(cap_q)) || (cnt_q == CW'(HEAP_DEPTH));

  assign flags_o.insert     = (mode_q == MODE_INSERT);
  assign flags_o.empty      = (cnt_q == '0);
  assign flags_o.not_remove = (mode_q != MODE_REMOVE);
  assign flags_o.no_left    = (left_w >= LW'(cnt_q));
  assign flags_o.no_right   = (right_w >= LW'(cnt_q));
  assign flags_o.dn_stop    = !out_of_order(val_q, pickv_q, min_q);
  assign flags_o.up_stop    = !out_of_order(rdata_s, val_q, min_q);
  assign flags_o.at_root    = (pos_q == '0);
  assign flags_o.full       = full_w;
  assign flags_o.out_busy   = out_valid_q && !out_ready_i;

  assign emit_fire = ctrl_i.emit && !flags_o.out_busy;

  // RAM port selection.
  always_comb begin
    case (ctrl_i.rd_sel)
      RD_ZERO:   mem_raddr_o = '0;
      RD_LAST:   mem_raddr_o = last_w;
      RD_LEFT:   mem_raddr_o = left_w[AW-1:0];
      RD_RIGHT:  mem_raddr_o = right_w[AW-1:0];
      RD_PARENT: mem_raddr_o = parent_w;
      default:   mem_raddr_o = '0;
    endcase
  end
  assign mem_re_o    = (ctrl_i.rd_sel != RD_NONE);
  assign mem_we_o    = (ctrl_i.wr_sel != WR_NONE);
  assign mem_waddr_o = pos_q;
  assign mem_wdata_o = (ctrl_i.wr_sel == WR_PICK) ? pickv_q : val_q;

  always_comb begin
    val_d   = val_q;
    res_d   = res_q;
    pickv_d = pickv_q;
    pick_d  = pick_q;
    if (accept) begin
      val_d = value_i;
      res_d = '0;
    end
    if (ctrl_i.ld_val) begin
      val_d = rdata_s;
    end
    if (ctrl_i.ld_res) begin
      res_d = rdata_s;
    end
    if (ctrl_i.ld_left) begin
      pickv_d = rdata_s;
      pick_d  = left_w[AW-1:0];
    end
    if (ctrl_i.ld_right_if && out_of_order(pickv_q, rdata_s, min_q)) begin
      pickv_d = rdata_s;
      pick_d  = right_w[AW-1:0];
    end
    if (ctrl_i.ld_upv) begin
      pickv_d = rdata_s;
    end
  end

  always_comb begin
    case (ctrl_i.pos_sel)
      POS_HOLD:   pos_d = pos_q;
      POS_ZERO:   pos_d = '0;
      POS_CNT:    pos_d = cnt_q[AW-1:0];
      POS_PICK:   pos_d = pick_q;
      POS_PARENT: pos_d = parent_w;
      default:    pos_d = pos_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CW'(1);
      CNT_DEC:  cnt_d = cnt_q - CW'(1);
      default:  cnt_d = cnt_q;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    res_q   <= res_d;
    pickv_q <= pickv_d;
    pick_q  <= pick_d;
    pos_q   <= pos_d;
    if (accept) begin
      mode_q <= mode_i;
    end
    if (emit_fire) begin
      out_val_q    <= (ctrl_i.emit_status == STATUS_OK) ? res_q : '0;
      out_cnt_q    <= COUNT_W'(cnt_q);
      out_status_q <= ctrl_i.emit_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      min_q       <= MIN_ORDER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CAPACITY:  cap_q <= cfg_data_i[CAP_W-1:0];
          CFG_MIN_ORDER: min_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_value_o  = out_val_q;
  assign element_count_o = out_cnt_q;
  assign status_o        = out_status_q;

  `BHPQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(HEAP_DEPTH), "element count above heap depth")
  `BHPQ_ASSERT(a_inc_not_full, clk_i, rst_ni, (ctrl_i.cnt_op == CNT_INC) |-> !full_w, "insert into a full heap")
  `BHPQ_ASSERT_NEVER(a_dec_empty, clk_i, rst_ni, (ctrl_i.cnt_op == CNT_DEC) && (cnt_q == '0), "remove from an empty heap")
  `BHPQ_ASSERT_NEVER(a_port_clash, clk_i, rst_ni, mem_we_o && mem_re_o, "heap RAM read and write in one step")

endmodule

FILE: rtl/core/binary_heap_priority_queue_core.sv
// Binary heap priority queue core: microcoded sequencer over a heap datapath
// and one heap RAM. Depends on bhpq_pkg, bhpq_seq, bhpq_dp and bhpq_ram.
//
// Priority queue of signed 32-bit values kept as an array binary heap in a
// single RAM of HEAP_DEPTH words (children of slot i at 2i+1 and 2i+2).
// Each input beat is a request: mode 0 inserts value, mode 1 removes the top,
// mode 2 (and 3) reads the top without removing it. Every request returns one
// output beat with the top value (zero for inserts and errors), the element
// count after the request and a status: ok, full (insert dropped, count kept)
// or empty (remove or read on an empty heap). Register 0 limits capacity
// (effective limit is the smaller of it and HEAP_DEPTH, elements already held
// above a lowered limit stay); register 1 selects min order (1, reset) or max
// order (0). Change configuration only while no request is in flight; the
// heap is not rebuilt on an order change. One request is worked at a time.
// An insert takes longer the more levels the new value climbs, and a remove
// the more levels the moved element sinks. After each result the program
// returns to its idle step before the next request is taken, and a result
// still waiting in the output register holds the load of the next one. The
// single read port of the heap RAM, whose read is registered, sets this cost.
// The result sits in an output register, so a new request is taken while the
// previous result still waits. No clearing pass after reset: the fill count
// guards the RAM.
module binary_heap_priority_queue_core #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [bhpq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bhpq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bhpq_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [bhpq_pkg::VALUE_W-1:0] value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bhpq_pkg::VALUE_W-1:0] result_value_o,
  output logic [bhpq_pkg::COUNT_W-1:0]        element_count_o,
  output logic [bhpq_pkg::STATUS_W-1:0]       status_o
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);

  ctrl_t              ctrl;
  flags_t             flags;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // Take a request beat only in the idle step of the program.
  assign in_ready_o = ctrl.wait_in;

  // Step counter and control ROM: advance, branch on datapath flags, hold
  // while the request channel is empty or the result register is occupied.
  bhpq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  // Sift registers, count, configuration, compare and result register.
  bhpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .result_value_o  (result_value_o),
    .element_count_o (element_count_o),
    .status_o        (status_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // Heap storage: one write and one registered read per cycle.
  bhpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: tb/sv/binary_heap_priority_queue_core_test.sv
// Self-checking testbench for the binary heap priority queue core.
// Depends on bhpq_pkg and binary_heap_priority_queue_core; drives random and
// directed requests and checks every result beat against a heap predictor.
module binary_heap_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam int DEPTH           = 1024;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int REPORT_CAP      = 100;
  localparam int PHASES          = 7;

  // Mode 3 is not in the package enum; the core treats it as a read.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
    status_e                   status;
  } heap_result_t;

  // Heap predictor plus the queue of results it owes. One request in, one
  // expected result out; result beats are matched in arrival order.
  class heap_scoreboard;
    logic signed [VALUE_W-1:0] slots [DEPTH];
    int unsigned               fill;
    logic [CAP_W-1:0]          cap_reg;
    logic                      min_first;
    heap_result_t              expected_q [$];
    int                        mismatches;
    int                        status_hits [3];

    function void clear();
      fill      = 0;
      cap_reg   = CAP_RESET;
      min_first = MIN_ORDER_RESET;
      mismatches = 0;
      expected_q.delete();
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_config(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CAPACITY) cap_reg = data[CAP_W-1:0];
      else min_first = data[0];
    endfunction

    // True when a belongs below b in the current order.
    function bit out_of_order(logic signed [VALUE_W-1:0] a, logic signed [VALUE_W-1:0] b);
      return min_first ? (a > b) : (a < b);
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      logic signed [VALUE_W-1:0] t;
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!out_of_order(slots[up], slots[pos])) break;
        swap_slots(up, pos);
        pos = up;
      end
    endfunction

    // Left child wins a tie; swap only on strict disorder.
    function void sift_down();
      int unsigned pos;
      int unsigned left;
      int unsigned pick;
      pos = 0;
      while (2 * pos + 1 < fill) begin
        left = 2 * pos + 1;
        pick = left;
        if (left + 1 < fill && out_of_order(slots[left], slots[left + 1])) pick = left + 1;
        if (!out_of_order(slots[pos], slots[pick])) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value);
      heap_result_t r;
      int unsigned  lim;
      lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
      r.value  = '0;
      r.status = STATUS_OK;
      if (mode == MODE_INSERT) begin
        if (fill >= lim) begin
          r.status = STATUS_FULL;
        end else begin
          slots[fill] = value;
          fill++;
          sift_up(fill - 1);
        end
      end else if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else if (mode == MODE_REMOVE) begin
        r.value  = slots[0];
        slots[0] = slots[fill - 1];
        fill--;
        sift_down();
      end else begin
        r.value = slots[0];
      end
      r.count = fill[COUNT_W-1:0];
      status_hits[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
      else if (mismatches == REPORT_CAP + 1)
        $display("%0t: further mismatch reports suppressed", $time);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] v, logic [COUNT_W-1:0] c,
                               logic [STATUS_W-1:0] s);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result beat, value", 0, v);
        return;
      end
      e = expected_q.pop_front();
      if (v !== e.value) report("result_value", e.value, v);
      if (c !== e.count) report("element_count", e.count, c);
      if (s !== e.status) report("status", e.status, s);
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [MODE_W-1:0]          mode_i;
  logic signed [VALUE_W-1:0]  value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [VALUE_W-1:0]  result_value_o;
  logic [COUNT_W-1:0]         element_count_o;
  logic [STATUS_W-1:0]        status_o;

  heap_scoreboard board = new;

  bit no_idle;        // both sides run back to back while set
  bit hold_off_req;   // ask the receiver for one long stall
  int hold_offs;
  int results_seen;
  int requests_sent;

  binary_heap_priority_queue_core #(
    .HEAP_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .element_count_o(element_count_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Lean on the extremes and on a narrow band so that ties are common.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'sh7fff_ffff;
    if (r == 1) return 32'sh8000_0000;
    if (r < 6) return $signed($urandom_range(0, 8)) - 4;
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return MODE_INSERT;
    r = $urandom_range(0, 99);
    if (r < 70) return MODE_REMOVE;
    if (r < 90) return MODE_READ;
    return MODE_SPARE;
  endfunction

  // Offer one request beat after a random gap and hold it until accepted.
  // Valid stays high across back-to-back beats; it only drops for a gap.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(mode, value);
    requests_sent++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One-cycle register write; only called while the core is idle.
  task automatic write_config(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_config(idx, data);
  endtask

  // Receiver: stall at random, accept a result beat, check it. When asked,
  // hold off for a long stretch so the core fills up and stalls its input.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (hold_off_req) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        hold_offs++;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_result(result_value_o, element_count_o, status_o);
      results_seen++;
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no beat accepted for %0d cycles", $time, quiet);
    $display("Mismatches found");
    $finish;
  end

  // Main sequence: reset, directed corner cases, then random phases that
  // each start from a fresh register setting.
  initial begin
    logic [CAP_W-1:0]      cap;
    logic                  order;
    logic [CFG_DATA_W-2:0] filler;
    int                    items;
    int                    insert_pct;
    int                    phase;
    int                    n;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_CAPACITY;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_INSERT;
    value_i     = '0;
    out_ready_i = 1'b0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    hold_offs     = 0;
    results_seen  = 0;
    requests_sent = 0;
    board.clear();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Empty heap: read, remove and the spare mode all report empty.
    send_request(MODE_READ, 32'sd0);
    send_request(MODE_REMOVE, 32'sh5a5a_a5a5);
    send_request(MODE_SPARE, -32'sd1);
    // Extremes of the value range and a tie, under reset min order.
    send_request(MODE_INSERT, 32'sh7fff_ffff);
    send_request(MODE_INSERT, 32'sh8000_0000);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_READ, 32'sh7fff_ffff);
    send_request(MODE_SPARE, 32'sd0);
    // Drain all five, then one more on the now empty heap.
    repeat (6) send_request(MODE_REMOVE, $urandom);

    // Capacity of one: the second insert is dropped.
    wait_idle();
    write_config(CFG_CAPACITY, 11'd1);
    send_request(MODE_INSERT, 32'sd7);
    send_request(MODE_INSERT, 32'sd8);
    send_request(MODE_READ, 32'sd0);
    // Capacity lowered below the count: the element stays, inserts drop.
    wait_idle();
    write_config(CFG_CAPACITY, 11'd0);
    send_request(MODE_INSERT, 32'sd9);
    send_request(MODE_REMOVE, 32'sd0);
    send_request(MODE_INSERT, 32'sd10);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          cap = 11'd1024; order = 1'b1; items = 200; insert_pct = 70;
        end
        1: begin
          // Flip to max order on a populated heap; no rebuild expected.
          cap = 11'd1024; order = 1'b0; items = 150; insert_pct = 50;
        end
        2: begin
          cap = 11'd12; order = 1'b1; items = 120; insert_pct = 55;
        end
        3: begin
          // Limit above the depth; run this one with no idling at all.
          cap = 11'd2047; order = 1'b0; items = 120; insert_pct = 55;
        end
        4: begin
          cap = 11'd0; order = 1'b1; items = 40; insert_pct = 40;
        end
        5: begin
          cap = 11'd1; order = 1'b0; items = 60; insert_pct = 50;
        end
        default: begin
          cap = 11'd300; order = 1'b1; items = 160; insert_pct = 70;
        end
      endcase
      wait_idle();
      filler = (CFG_DATA_W-1)'($urandom);
      write_config(CFG_CAPACITY, cap);
      write_config(CFG_MIN_ORDER, {filler, order});
      no_idle = (phase == 3);
      for (n = 0; n < items; n++) begin
        if (phase == 1 && n == 30) hold_off_req = 1'b1;
        send_request(pick_mode(insert_pct), pick_value());
      end
    end

    // Let the last beats land, then watch a while for strays.
    wait_idle();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests over %0d register settings plus directed corners;",
             requests_sent, PHASES + 2);
    $display("results checked %0d: ok %0d, full %0d, empty %0d; long receiver stalls %0d.",
             results_seen, board.status_hits[STATUS_OK], board.status_hits[STATUS_FULL],
             board.status_hits[STATUS_EMPTY], hold_offs);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_ram.sv
rtl/core/bhpq_seq.sv
rtl/core/bhpq_dp.sv
rtl/core/binary_heap_priority_queue_core.sv
tb/sv/binary_heap_priority_queue_core_test.sv
